[rtl/core/tirt_pkg.sv]
// Shared types and constants for the transaction id ring table.
// Used by tirt_front, tirt_back and transaction_id_ring_table_core.
package tirt_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int PADDR_W         = 3;
  localparam int FIFO_DEPTH      = 2;

  localparam logic [15:0] SPAN_RESET = 16'd5;
  localparam logic        REG_DEADLINE_SPAN = 1'b0;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_RETIRE = 2'd1;
  localparam logic [1:0] OP_MARK   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] client_addr;
    logic [15:0] client_port;
    logic [15:0] original_id;
    logic [7:0]  target_slot;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  new_slot;
    logic [31:0] entry_addr;
    logic [15:0] entry_port;
    logic [15:0] entry_original_id;
    logic        entry_replied;
    logic [31:0] entry_deadline;
  } out_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] original_id;
    logic [31:0] deadline;
  } slot_t;

endpackage

[rtl/core/tirt_front.sv]
// Front end: accepts transactions into a two-entry queue for the back end.
// Depends on tirt_pkg.
module tirt_front
  import tirt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic q_valid,
  output in_t  q_item,
  input  logic q_pop
);

  in_t        buf_r [FIFO_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_stall = (cnt_r == 2'(FIFO_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

[rtl/core/tirt_back.sv]
// Back end: ring indexes, slot memories, operation sequencer, result register.
// Depends on tirt_pkg; fed by tirt_front.
module tirt_back
  import tirt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  in_t         q_item,
  output logic        q_pop,
  input  logic [15:0] span,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int WW    = IDX_W + 8;

  typedef enum logic [1:0] {ST_IDLE, ST_RETIRE, ST_MARK, ST_READ} state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  in_t              cur_r, cur_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  slot_t            dmem [QUEUE_DEPTH];
  logic             rmem [QUEUE_DEPTH];
  slot_t            rd_dat_r;
  logic             rd_rep_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             we_d;
  logic             we_r;
  logic             wr_rep;
  slot_t            wr_dat;

  logic             out_free;
  logic [IDX_W-1:0] tail_next;
  logic [IDX_W-1:0] head_next;
  logic [WW-1:0]    q_wide;
  logic [WW-1:0]    c_wide;
  logic [WW-1:0]    t_wide;
  logic [IDX_W-1:0] q_sidx;
  logic [IDX_W-1:0] c_sidx;
  logic             q_live;
  logic             expired;
  out_t             res;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign tail_next = ring_next(tail_r);
  assign head_next = ring_next(head_r);
  assign q_wide    = {{IDX_W{1'b0}}, q_item.target_slot};
  assign c_wide    = {{IDX_W{1'b0}}, cur_r.target_slot};
  assign t_wide    = {8'd0, tail_r};
  assign q_sidx    = q_wide[IDX_W-1:0];
  assign c_sidx    = c_wide[IDX_W-1:0];
  assign expired   = rd_rep_r || (rd_dat_r.deadline < cur_r.now);

  always_comb begin
    if (q_wide >= WW'(QUEUE_DEPTH)) begin
      q_live = 1'b0;
    end else if (head_r <= tail_r) begin
      q_live = (q_sidx >= head_r) && (q_sidx < tail_r);
    end else begin
      q_live = (q_sidx < tail_r) || (q_sidx >= head_r);
    end
  end

  assign wr_dat.addr        = q_item.client_addr;
  assign wr_dat.port        = q_item.client_port;
  assign wr_dat.original_id = q_item.original_id;
  assign wr_dat.deadline    = q_item.now + {16'd0, span};

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    we_d          = 1'b0;
    we_r          = 1'b0;
    wr_addr       = tail_r;
    wr_rep        = 1'b0;
    rd_addr       = head_r;
    res           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          unique case (q_item.op)
            OP_PUSH: begin
              if (tail_next != head_r) begin
                we_d         = 1'b1;
                we_r         = 1'b1;
                res.ok       = 1'b1;
                res.new_slot = t_wide[7:0];
                tail_nxt     = tail_next;
              end
              out_valid_nxt = 1'b1;
              out_nxt       = res;
            end
            OP_RETIRE: begin
              if (head_r == tail_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = res;
              end else begin
                state_nxt = ST_RETIRE;
              end
            end
            default: begin
              rd_addr = q_sidx;
              if (q_live) begin
                state_nxt = (q_item.op == OP_MARK) ? ST_MARK : ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = res;
              end
            end
          endcase
        end
      end
      ST_RETIRE: begin
        res.ok = 1'b1;
        if (expired && (head_next != tail_r)) begin
          head_nxt = head_next;
          rd_addr  = head_next;
        end else begin
          if (expired) begin
            head_nxt = head_next;
          end
          out_valid_nxt = 1'b1;
          out_nxt       = res;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (!rd_rep_r) begin
          we_r    = 1'b1;
          wr_addr = c_sidx;
          wr_rep  = 1'b1;
          res.ok  = 1'b1;
        end
        out_valid_nxt = 1'b1;
        out_nxt       = res;
        state_nxt     = ST_IDLE;
      end
      ST_READ: begin
        res.ok                = 1'b1;
        res.entry_addr        = rd_dat_r.addr;
        res.entry_port        = rd_dat_r.port;
        res.entry_original_id = rd_dat_r.original_id;
        res.entry_replied     = rd_rep_r;
        res.entry_deadline    = rd_dat_r.deadline;
        out_valid_nxt         = 1'b1;
        out_nxt               = res;
        state_nxt             = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_d) begin
      dmem[wr_addr] <= wr_dat;
    end
    if (we_r) begin
      rmem[wr_addr] <= wr_rep;
    end
    rd_dat_r <= dmem[rd_addr];
    rd_rep_r <= rmem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/transaction_id_ring_table_core.sv]
// Top level of the transaction id ring table: config register, front and back.
// Depends on tirt_pkg, tirt_front and tirt_back.
//
//   Port group   Direction  Payload    Transfer
//   in_          input      in_t       in_valid high, in_stall low
//   out_         output     out_t      out_valid high, out_stall low
//   cfg_         APB        32-bit     psel, penable, pwrite, pready high
//
// Push answers from idle; mark and read answer from ST_MARK or ST_READ, or from idle
// for a slot outside the live range. Retire answers from idle on an empty table;
// else ST_RETIRE drops expired heads, one slot memory read per cycle.
// Reset clears head, tail, queue and result state; slot memories are not cleared.
// A stalled result holds the back end, while the front queue keeps accepting
// up to two transactions.
module transaction_id_ring_table_core
  import tirt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [15:0] span_r, span_nxt;
  logic        q_valid;
  in_t         q_item;
  logic        q_pop;
  logic        sel_span;

  assign cfg_pready = 1'b1;
  assign sel_span   = (cfg_paddr[2] == REG_DEADLINE_SPAN);
  assign cfg_prdata = sel_span ? {16'd0, span_r} : 32'd0;

  always_comb begin
    span_nxt = span_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_span) begin
      span_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SPAN_RESET;
    end else begin
      span_r <= span_nxt;
    end
  end

  tirt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tirt_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .span      (span_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[tb/tb.sv]
// Testbench for transaction_id_ring_table_core: random and directed transactions
// checked against an in-bench model of the slot ring. Depends on tirt_pkg.
class ring_table_scoreboard;
  tirt_pkg::out_t pending[$];
  logic [15:0] span;
  logic [7:0] head, tail;
  logic [31:0] s_addr [256];
  logic [15:0] s_port [256];
  logic [15:0] s_oid [256];
  logic s_rep [256];
  logic [31:0] s_dl [256];
  int errors;

  function new();
    span = tirt_pkg::SPAN_RESET;
    head = 0;
    tail = 0;
    errors = 0;
  endfunction

  function bit is_live(logic [7:0] s);
    if (head <= tail) return s >= head && s < tail;
    return s < tail || s >= head;
  endfunction

  function int occupancy();
    return int'(tail - head) & 255;
  endfunction

  function void note_input(tirt_pkg::in_t t);
    tirt_pkg::out_t r;
    r = '0;
    case (t.op)
      tirt_pkg::OP_PUSH: begin
        if (8'(tail + 1) != head) begin
          s_addr[tail] = t.client_addr;
          s_port[tail] = t.client_port;
          s_oid[tail] = t.original_id;
          s_rep[tail] = 1'b0;
          s_dl[tail] = t.now + 32'(span);
          r.ok = 1'b1;
          r.new_slot = tail;
          tail = tail + 1;
        end
      end
      tirt_pkg::OP_RETIRE: begin
        if (head != tail) begin
          while (head != tail && (s_rep[head] || s_dl[head] < t.now)) head = head + 1;
          r.ok = 1'b1;
        end
      end
      tirt_pkg::OP_MARK: begin
        if (is_live(t.target_slot) && !s_rep[t.target_slot]) begin
          s_rep[t.target_slot] = 1'b1;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (is_live(t.target_slot)) begin
          r.ok = 1'b1;
          r.entry_addr = s_addr[t.target_slot];
          r.entry_port = s_port[t.target_slot];
          r.entry_original_id = s_oid[t.target_slot];
          r.entry_replied = s_rep[t.target_slot];
          r.entry_deadline = s_dl[t.target_slot];
        end
      end
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(tirt_pkg::out_t got);
    tirt_pkg::out_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got.ok !== want.ok || got.new_slot !== want.new_slot
        || got.entry_addr !== want.entry_addr || got.entry_port !== want.entry_port
        || got.entry_original_id !== want.entry_original_id
        || got.entry_replied !== want.entry_replied
        || got.entry_deadline !== want.entry_deadline) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
    end
  endfunction
endclass

module tb;
  import tirt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ring_table_scoreboard ledger = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int cycle_count = 0;
  logic [31:0] clock_now = 32'd100;

  transaction_id_ring_table_core i_dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_result(out_data);
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_off_cycles <= 400;
      out_stall <= 1'b1;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send(in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_input(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_span(logic [15:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= PADDR_W'(REG_DEADLINE_SPAN) << 2;
    cfg_pwdata <= {16'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    ledger.span = v;
  endtask

  function automatic in_t make_item(logic [1:0] op, logic [7:0] s);
    in_t t;
    t.op = op;
    t.client_addr = $urandom;
    t.client_port = 16'($urandom);
    t.original_id = 16'($urandom);
    t.target_slot = s;
    t.now = clock_now;
    return t;
  endfunction

  task automatic random_items(int n);
    in_t t;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) clock_now = clock_now + $urandom_range(8);
      if (pick < 40) t = make_item(OP_PUSH, 8'($urandom));
      else if (pick < 55) t = make_item(OP_RETIRE, 8'($urandom));
      else if (pick < 75)
        t = make_item(OP_MARK, ledger.head + 8'($urandom_range(ledger.occupancy() + 2)));
      else
        t = make_item(OP_READ, ledger.head + 8'($urandom_range(ledger.occupancy() + 2)));
      if ($urandom_range(19) == 0) t.target_slot = 8'($urandom);
      if ($urandom_range(29) == 0) t.now = $urandom;
      send(t);
    end
  endtask

  initial begin
    in_t t;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(make_item(OP_RETIRE, 8'h00));
    send(make_item(OP_READ, 8'h00));
    send(make_item(OP_MARK, 8'hff));
    t = make_item(OP_PUSH, 8'h00);
    t.client_addr = '1; t.client_port = '1; t.original_id = '1;
    send(t);
    t = make_item(OP_PUSH, 8'hff);
    t.client_addr = '0; t.client_port = '0; t.original_id = '0; t.now = 32'hffff_fffe;
    send(t);
    send(make_item(OP_READ, 8'h00));
    send(make_item(OP_READ, 8'h01));
    send(make_item(OP_READ, 8'h02));
    send(make_item(OP_MARK, 8'h00));
    send(make_item(OP_MARK, 8'h00));
    send(make_item(OP_READ, 8'h00));
    send(make_item(OP_RETIRE, 8'h00));
    t = make_item(OP_RETIRE, 8'h00); t.now = '1;
    send(t);
    send(make_item(OP_RETIRE, 8'h00));
    drain();

    write_span(16'hffff);
    t = make_item(OP_PUSH, 8'h00); t.now = 32'hffff_0100;
    send(t);
    send(make_item(OP_READ, ledger.head));
    drain();
    write_span(16'h0000);

    send_idle_pct = 0;
    hold_req <= 1'b1;
    random_items(8);
    drain();
    for (int i = 0; i < 260; i++) send(make_item(OP_PUSH, 8'h00));
    send(make_item(OP_READ, 8'hfe));
    drain();
    clock_now = clock_now + 10;
    send(make_item(OP_RETIRE, 8'h00));
    drain();

    write_span(16'd3);
    send_idle_pct = 28; recv_idle_pct = 54;
    random_items(160);
    drain();
    write_span(16'd40);
    send_idle_pct = 54; recv_idle_pct = 28;
    random_items(160);
    drain();
    write_span(16'd0);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_items(160);
    drain();

    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
